// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be seen on a clock edge.
`define BDQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`BDQ_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// File: src/bdq_pkg.sv
// Package: types, constants and ring index helpers of the deque.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int WORD_W    = 32;
	localparam int CAP_W     = 7;
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(64);
	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK       = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic [2:0]               op;
		logic signed [WORD_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] rear_word;
		logic                     is_empty;
		logic                     is_full;
	} rsp_word_t;

	// pos + delta modulo MAX_DEPTH; pos < MAX_DEPTH, delta <= MAX_DEPTH
	function automatic idx_t ring_add(idx_t pos, cnt_t delta);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(pos) + {1'b0, delta};
		if (s >= (CNT_W+1)'(MAX_DEPTH)) begin
			s = s - (CNT_W+1)'(MAX_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_dec(idx_t pos);
		return (pos == '0) ? IDX_W'(MAX_DEPTH - 1) : pos - 1'b1;
	endfunction

endpackage

// File: src/bounded_double_ended_queue.sv
// Bounded deque top level: ring pointers, count, capacity and sequencing.
// Sequencing: a request is taken in IDLE, with any push write; READ reads
//   the front/rear words from the ring RAM and LOAD moves them into the output
//   register. The request side stalls until the sequencer is back in IDLE, so
//   a new request is not taken before the last one is loaded; LOAD waits while
//   a stalled response word still holds the output register.
// Reset: head, count and the sequencer clear, capacity returns to 64; the
//   ring RAM is not cleared and holds no valid bits.
`timescale 1ns / 1ps

module bounded_double_ended_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     req_valid,
	output logic                     req_stall,
	input  bdq_pkg::req_word_t       req,
	// response channel
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output bdq_pkg::rsp_word_t       rsp,
	// capacity write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [bdq_pkg::CAP_W-1:0] cfg_data
);

	// ------------------------------------------------------------------
	// Architectural state: front pointer, entry count, capacity register.
	// ------------------------------------------------------------------
	bdq_pkg::idx_t             head_q;
	bdq_pkg::cnt_t             count_q;
	logic [bdq_pkg::CAP_W-1:0] cap_q;
	bdq_pkg::state_t           state_q, state_n;

	// Per-request values held while the RAM read is under way.
	logic           ok_s1;
	logic           empty_s1;
	logic           full_s1;
	bdq_pkg::idx_t  fidx_s1;
	bdq_pkg::idx_t  ridx_s1;

	// Output register, frees the request side while a word waits.
	logic               rsp_valid_q;
	bdq_pkg::rsp_word_t rsp_q;
	bdq_pkg::rsp_word_t rsp_n;

	// Request decode
	logic           accept;
	logic           ram_re;
	logic           load_en;
	bdq_pkg::cnt_t  lim;
	logic           can_push;
	logic           has_item;
	bdq_pkg::idx_t  head_n;
	bdq_pkg::cnt_t  count_n;
	bdq_pkg::idx_t  rear_n;
	logic           ok_n;
	logic           we_n;
	bdq_pkg::idx_t  waddr_n;

	logic [bdq_pkg::WORD_W-1:0] rd_front;
	logic [bdq_pkg::WORD_W-1:0] rd_rear;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Next pointers and count. Capacity above the ring depth saturates.
	// Full uses equality, so a count above a lowered capacity is not full.
	// ------------------------------------------------------------------
	always_comb begin
		lim = (bdq_pkg::CMP_W'(cap_q) > bdq_pkg::CMP_W'(bdq_pkg::MAX_DEPTH)) ?
			bdq_pkg::CNT_W'(bdq_pkg::MAX_DEPTH) : bdq_pkg::CNT_W'(cap_q);
		can_push = count_q < lim;
		has_item = count_q != '0;
		head_n   = head_q;
		count_n  = count_q;
		ok_n     = 1'b0;
		we_n     = 1'b0;
		waddr_n  = head_q;
		case (req.op)
			bdq_pkg::OP_PUSH_FRONT: begin
				if (can_push) begin
					head_n  = bdq_pkg::ring_dec(head_q);
					count_n = count_q + 1'b1;
					waddr_n = head_n;
					we_n    = 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::OP_PUSH_REAR: begin
				if (can_push) begin
					count_n = count_q + 1'b1;
					waddr_n = bdq_pkg::ring_add(head_q, count_q);
					we_n    = 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (has_item) begin
					head_n  = bdq_pkg::ring_add(head_q, bdq_pkg::CNT_W'(1));
					count_n = count_q - 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::OP_POP_REAR: begin
				if (has_item) begin
					count_n = count_q - 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::OP_PEEK: begin
				ok_n = 1'b1;
			end
			default: begin
				// unused codes: refused, queue untouched
				ok_n = 1'b0;
			end
		endcase
		// rear address only matters when the queue stays non-empty
		rear_n = bdq_pkg::ring_add(head_n, count_n - 1'b1);
	end

	// ------------------------------------------------------------------
	// Sequencer: IDLE takes a request and does the push write, READ issues
	// the front/rear reads, LOAD moves the read data into the output
	// register. The write is registered as IDLE is left, before any read, so a push is
	// always seen by its own reads without a bypass path.
	// ------------------------------------------------------------------
	always_comb begin
		state_n = state_q;
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_n = bdq_pkg::ST_READ;
				end
			end
			bdq_pkg::ST_READ: begin
				state_n = bdq_pkg::ST_LOAD;
			end
			bdq_pkg::ST_LOAD: begin
				if (load_en) begin
					state_n = bdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		ram_re    = 1'b0;
		load_en   = 1'b0;
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			bdq_pkg::ST_READ: begin
				ram_re = 1'b1;
			end
			bdq_pkg::ST_LOAD: begin
				// load when the output register is empty or drains now
				load_en = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= bdq_pkg::CAP_RESET;
		end else begin
			state_q <= state_n;
			if (accept) begin
				head_q  <= head_n;
				count_q <= count_n;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	// Request-side values for the read and load steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1    <= ok_n;
			empty_s1 <= (count_n == '0);
			full_s1  <= (count_n == lim);
			fidx_s1  <= head_n;
			ridx_s1  <= rear_n;
		end
	end

	bdq_ram #(
		.DEPTH (bdq_pkg::MAX_DEPTH),
		.WIDTH (bdq_pkg::WORD_W),
		.AW    (bdq_pkg::IDX_W)
	) u_ring (
		.clk     (clk),
		.we      (accept && we_n),
		.waddr   (waddr_n),
		.wdata   (req.value),
		.re      (ram_re),
		.raddr_a (fidx_s1),
		.raddr_b (ridx_s1),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Empty queue reports all ones in both word fields.
	always_comb begin
		rsp_n.ok         = ok_s1;
		rsp_n.front_word = empty_s1 ? bdq_pkg::EMPTY_WORD : $signed(rd_front);
		rsp_n.rear_word  = empty_s1 ? bdq_pkg::EMPTY_WORD : $signed(rd_rear);
		rsp_n.is_empty   = empty_s1;
		rsp_n.is_full    = full_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_en) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			rsp_q <= rsp_n;
		end
	end

endmodule

// File: src/bdq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module bdq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: src/bdq_checker.sv
// Port checker for the deque top level, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input bdq_pkg::rsp_word_t        rsp
);

	// a held response word stays put
	`BDQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response word changed while stalled")

	// empty queue shows all ones at both ends
	`BDQ_ASSERT(a_empty_words, clk, arst_n, rsp_valid && rsp.is_empty |-> rsp.front_word == bdq_pkg::EMPTY_WORD && rsp.rear_word == bdq_pkg::EMPTY_WORD, "empty response carries a word")

	// a taken request keeps the request side closed through the READ and LOAD states
	`BDQ_ASSERT(a_busy_after_take, clk, arst_n, req_valid && !req_stall |=> req_stall ##1 req_stall, "request taken while busy")

	// a fresh response word is first seen after its request has passed the READ and LOAD states
	`BDQ_ASSERT(a_rsp_latency, clk, arst_n, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3), "response without a matching request")

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);
